// ===== design/ppd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the point-to-plane distance block.
// Holds the field widths and derived internal widths; no dependencies.
`default_nettype none
package ppd_pkg;
  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 24;
  // Coordinate differences carry one extra bit.
  localparam int DW   = COORD_BITS + 1;
  // Products of two differences, and the normal magnitude.
  localparam int PW   = 2 * DW;
  // Magnitude of N . (P - A).
  localparam int NUMW = 3 * DW;
  // |N|^2.
  localparam int NNW  = 4 * DW;
  // Square of the numerator and the working remainder.
  localparam int TW   = 2 * NUMW;
  // Register stages ahead of the per-bit stages.
  localparam int PRE  = 10;
  localparam int NS   = PRE + DIST_BITS;
endpackage
`default_nettype wire

// ===== design/ppd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the point-to-plane distance block: three plane points and a query point.
// Depends on ppd_pkg.
`default_nettype none
interface ppd_in_if;
  import ppd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;
  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                  input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                output ready);
endinterface
`default_nettype wire

// ===== design/ppd_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the point-to-plane distance block.
// Depends on ppd_pkg.
`default_nettype none
interface ppd_out_if;
  import ppd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic                 degenerate;
  logic                 saturated;
  modport source (output valid, distance, degenerate, saturated, input ready);
  modport sink (input valid, distance, degenerate, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/point_plane_distance_top.sv =====
`timescale 1ns / 1ps
// Point-to-plane distance pipeline, top level.
// Depends on ppd_pkg, ppd_in_if and ppd_out_if.
`default_nettype none
// Takes one beat per clock while the output is not stalled and returns one result beat
// per input beat, in order. Ten stages form the normal, N.(P-A), |N|^2 and the square
// of the numerator with narrow multipliers; then one stage per result bit (24 stages)
// finds the largest q with q*q*|N|^2 <= (N.(P-A))^2 by add-and-compare, so the root
// and division are exact.
// Every stage has its own valid bit and stalls only when the stage after it is full,
// so holes in the pipe fill up while the output waits. Collinear points give
// distance 0 with degenerate set; distances of 2^24 LSB or more saturate.
module point_plane_distance_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppd_in_if.sink    in_i,
  ppd_out_if.source out_o
);
  import ppd_pkg::*;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_o.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = ~v_q[s] | en[s+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // Stage 0: differences B-A, C-A, P-A.
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [DW-1:0] e_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d1_q[0] <= DW'(in_i.bx) - DW'(in_i.ax);
      d1_q[1] <= DW'(in_i.by_coord) - DW'(in_i.ay);
      d1_q[2] <= DW'(in_i.bz) - DW'(in_i.az);
      d2_q[0] <= DW'(in_i.cx) - DW'(in_i.ax);
      d2_q[1] <= DW'(in_i.cy) - DW'(in_i.ay);
      d2_q[2] <= DW'(in_i.cz) - DW'(in_i.az);
      e_q[0]  <= DW'(in_i.px) - DW'(in_i.ax);
      e_q[1]  <= DW'(in_i.py) - DW'(in_i.ay);
      e_q[2]  <= DW'(in_i.pz) - DW'(in_i.az);
    end
  end

  // Stage 1: the six cross-product terms.
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [DW-1:0] e1_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pa_q[0] <= d1_q[1] * d2_q[2];
      pb_q[0] <= d1_q[2] * d2_q[1];
      pa_q[1] <= d1_q[2] * d2_q[0];
      pb_q[1] <= d1_q[0] * d2_q[2];
      pa_q[2] <= d1_q[0] * d2_q[1];
      pb_q[2] <= d1_q[1] * d2_q[0];
      e1_q    <= e_q;
    end
  end

  // Stage 2: normal components as magnitude and sign.
  logic [PW-1:0] nabs_q [3];
  logic [DW-1:0] eabs_q [3];
  logic          psg_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [PW:0] n;
        n = (PW+1)'(pa_q[k]) - (PW+1)'(pb_q[k]);
        nabs_q[k] <= n[PW] ? PW'(-n) : PW'(n);
        eabs_q[k] <= e1_q[k][DW-1] ? DW'(-e1_q[k]) : DW'(e1_q[k]);
        psg_q[k]  <= n[PW] ^ e1_q[k][DW-1];
      end
    end
  end

  // Stage 3: half-width partial products of N*e and N*N.
  logic [PW-1:0] nel_q [3];
  logic [PW-1:0] neh_q [3];
  logic [PW-1:0] nll_q [3];
  logic [PW-1:0] nlh_q [3];
  logic [PW-1:0] nhh_q [3];
  logic          psg3_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        nel_q[k]  <= nabs_q[k][DW-1:0] * eabs_q[k];
        neh_q[k]  <= nabs_q[k][PW-1:DW] * eabs_q[k];
        nll_q[k]  <= nabs_q[k][DW-1:0] * nabs_q[k][DW-1:0];
        nlh_q[k]  <= nabs_q[k][DW-1:0] * nabs_q[k][PW-1:DW];
        nhh_q[k]  <= nabs_q[k][PW-1:DW] * nabs_q[k][PW-1:DW];
        psg3_q[k] <= psg_q[k];
      end
    end
  end

  // Stage 4: assemble signed N_k*e_k and N_k^2.
  logic signed [NUMW:0] ne_q  [3];
  logic [NNW-1:0]       nnk_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        logic [NUMW-1:0] m;
        m = (NUMW'(neh_q[k]) << DW) + NUMW'(nel_q[k]);
        ne_q[k]  <= psg3_q[k] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        nnk_q[k] <= (NNW'(nhh_q[k]) << PW) + (NNW'(nlh_q[k]) << (DW + 1))
                  + NNW'(nll_q[k]);
      end
    end
  end

  // Stage 5: dot product magnitude and |N|^2.
  logic [NUMW-1:0] num_q;
  logic [NNW-1:0]  nn5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      logic signed [NUMW:0] s;
      s = ne_q[0] + ne_q[1] + ne_q[2];
      num_q <= s[NUMW] ? NUMW'(-s) : NUMW'(s);
      nn5_q <= nnk_q[0] + nnk_q[1] + nnk_q[2];
    end
  end

  // Stage 6: partial products of the numerator square, in three digits.
  logic [PW-1:0]  s00_q, s11_q, s22_q, s01_q, s02_q, s12_q;
  logic [NNW-1:0] nn6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s00_q <= num_q[DW-1:0] * num_q[DW-1:0];
      s11_q <= num_q[PW-1:DW] * num_q[PW-1:DW];
      s22_q <= num_q[NUMW-1:PW] * num_q[NUMW-1:PW];
      s01_q <= num_q[DW-1:0] * num_q[PW-1:DW];
      s02_q <= num_q[DW-1:0] * num_q[NUMW-1:PW];
      s12_q <= num_q[PW-1:DW] * num_q[NUMW-1:PW];
      nn6_q <= nn5_q;
    end
  end

  // Stage 7: two half sums of the square.
  logic [TW-1:0]  ta_q, tb_q;
  logic [NNW-1:0] nn7_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      ta_q  <= TW'(s00_q) + (TW'(s01_q) << (DW + 1)) + (TW'(s11_q) << PW);
      tb_q  <= (TW'(s02_q) << (PW + 1)) + (TW'(s12_q) << (3 * DW + 1))
             + (TW'(s22_q) << NNW);
      nn7_q <= nn6_q;
    end
  end

  // Stage 8: the full square of the numerator.
  logic [TW-1:0]  t8_q;
  logic [NNW-1:0] nn8_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      t8_q  <= ta_q + tb_q;
      nn8_q <= nn7_q;
    end
  end

  // Stage 9 seeds the bit search; entry k+1 is written by search stage k.
  logic [TW-1:0]        r_q   [DIST_BITS+1];
  logic [TW-1:0]        y_q   [DIST_BITS+1];
  logic [NNW-1:0]       nn_q  [DIST_BITS+1];
  logic [DIST_BITS-1:0] qv_q  [DIST_BITS+1];
  logic                 sat_q [DIST_BITS+1];
  logic                 deg_q [DIST_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en[PRE-1]) begin
      r_q[0]   <= t8_q;
      y_q[0]   <= '0;
      nn_q[0]  <= nn8_q;
      qv_q[0]  <= '0;
      sat_q[0] <= (TW'(nn8_q) << (2 * DIST_BITS)) <= t8_q;
      deg_q[0] <= (nn8_q == '0);
    end
  end

  // Search stage k decides bit i = DIST_BITS-1-k of q. With R = T - q^2*nn and
  // Y = q*nn, setting the bit costs 2^(i+1)*Y + 2^(2i)*nn out of R.
  for (genvar k = 0; k < DIST_BITS; k++) begin : g_bit
    localparam int I = DIST_BITS - 1 - k;
    logic [TW-1:0] cost;
    assign cost = (y_q[k] << (I + 1)) + (TW'(nn_q[k]) << (2 * I));

    always_ff @(posedge clk_i) begin
      if (en[PRE+k]) begin
        nn_q[k+1]  <= nn_q[k];
        sat_q[k+1] <= sat_q[k];
        deg_q[k+1] <= deg_q[k];
        if (cost <= r_q[k]) begin
          r_q[k+1]  <= r_q[k] - cost;
          y_q[k+1]  <= y_q[k] + (TW'(nn_q[k]) << I);
          qv_q[k+1] <= qv_q[k] | (DIST_BITS'(1) << I);
        end else begin
          r_q[k+1]  <= r_q[k];
          y_q[k+1]  <= y_q[k];
          qv_q[k+1] <= qv_q[k];
        end
      end
    end
  end

  assign out_o.valid      = v_q[NS-1];
  assign out_o.degenerate = deg_q[DIST_BITS];
  assign out_o.saturated  = sat_q[DIST_BITS] & ~deg_q[DIST_BITS];
  assign out_o.distance   = deg_q[DIST_BITS] ? '0 :
                            sat_q[DIST_BITS] ? '1 : qv_q[DIST_BITS];

endmodule
`default_nettype wire
